[design/pts_pkg.sv]
package pts_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int MAX_OUT   = 16;
    localparam int TAG_W     = 16;
    localparam int TIME_W    = 32;
    localparam int RUN_W     = 8;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ADD      = 2'd1,
        OP_DELETE   = 2'd2,
        OP_DISPATCH = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_FULL    = 3'd1,
        ST_INVALID = 3'd2,
        ST_READY   = 3'd3,
        ST_NONE    = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [TAG_W-1:0]   task_tag;
        logic [TIME_W-1:0]  first_delay;
        logic [TIME_W-1:0]  repeat_period;
        logic [7:0]         target_slot;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [3:0]         slot_number;
        logic [TAG_W-1:0]   ready_tag;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [TIME_W-1:0]  delay;
        logic [TIME_W-1:0]  period;
        logic [RUN_W-1:0]   runs;
    } t_slot_rec;

endpackage

[design/pts_slot_mem.sv]
module pts_slot_mem
    import pts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  t_slot_rec         i_wdata,
    input  logic              i_re,
    input  logic [IDX_W-1:0]  i_raddr,
    output t_slot_rec         o_rdata
);

    // One write port and one read port; read data is registered, so it arrives in the cycle after the read.
    t_slot_rec r_mem [SLOTS];
    t_slot_rec r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/pts_seq.sv]
module pts_seq
    import pts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_item             i_item,
    output logic              o_strobe,
    output t_result           o_result,
    output logic              o_mem_we,
    output logic [IDX_W-1:0]  o_mem_waddr,
    output t_slot_rec         o_mem_wdata,
    output logic              o_mem_re,
    output logic [IDX_W-1:0]  o_mem_raddr,
    input  t_slot_rec         i_mem_rdata
);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

    t_state             r_state, n_state;
    t_op                r_op, n_op;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [SLOTS-1:0]   r_used, n_used;
    logic [SLOTS-1:0]   r_pend, n_pend;
    logic               r_out_valid, n_out_valid;
    t_result            r_out, n_out;

    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   del_idx;
    logic               del_ok;
    logic [SLOTS-1:0]   pend_above;
    t_slot_rec          rec;
    logic [RUN_W-1:0]   runs_dec;

    // Lowest free slot for an add.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(s);
            end
        end
    end

    assign del_idx    = i_item.target_slot[IDX_W-1:0];
    assign del_ok     = ({1'b0, i_item.target_slot} < 9'(SLOTS)) && r_used[del_idx];
    assign pend_above = (r_pend >> r_idx) >> 1;
    assign rec        = i_mem_rdata;
    assign runs_dec   = rec.runs - 1'b1;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_idx       = r_idx;
        n_n         = r_n;
        n_used      = r_used;
        n_pend      = r_pend;
        n_out_valid = 1'b0;
        n_out       = '0;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_idx;
        o_mem_wdata = rec;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (i_item.op)
                        OP_TICK, OP_DISPATCH: begin
                            n_op     = i_item.op;
                            n_state  = S_SCAN;
                            n_idx    = '0;
                            n_n      = '0;
                            o_mem_re = 1'b1;
                        end
                        OP_ADD: begin
                            n_out_valid = 1'b1;
                            n_out.last  = 1'b1;
                            if (free_found) begin
                                o_mem_we           = 1'b1;
                                o_mem_waddr        = free_idx;
                                o_mem_wdata.tag    = i_item.task_tag;
                                o_mem_wdata.delay  = i_item.first_delay;
                                o_mem_wdata.period = i_item.repeat_period;
                                o_mem_wdata.runs   = '0;
                                n_used[free_idx]   = 1'b1;
                                n_pend[free_idx]   = 1'b0;
                                n_out.status       = ST_DONE;
                                n_out.slot_number  = 4'(free_idx);
                            end else begin
                                n_out.status = ST_FULL;
                            end
                        end
                        OP_DELETE: begin
                            n_out_valid = 1'b1;
                            n_out.last  = 1'b1;
                            if (del_ok) begin
                                n_used[del_idx] = 1'b0;
                                n_pend[del_idx] = 1'b0;
                                n_out.status    = ST_DONE;
                            end else begin
                                n_out.status = ST_INVALID;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Read ahead the next slot while this one is written back.
                if (r_idx != IDX_LAST) begin
                    o_mem_re    = 1'b1;
                    o_mem_raddr = r_idx + 1'b1;
                    n_idx       = r_idx + 1'b1;
                end else begin
                    n_state = S_IDLE;
                end

                if (r_op == OP_TICK) begin
                    if (r_used[r_idx]) begin
                        o_mem_we = 1'b1;
                        if (rec.delay == '0) begin
                            if (rec.runs != RUN_MAX) begin
                                o_mem_wdata.runs = rec.runs + 1'b1;
                            end
                            if (rec.period != '0) begin
                                o_mem_wdata.delay = rec.period;
                            end
                            n_pend[r_idx] = 1'b1;
                        end else begin
                            o_mem_wdata.delay = rec.delay - 1'b1;
                        end
                    end
                    if (r_idx == IDX_LAST) begin
                        n_out_valid  = 1'b1;
                        n_out.status = ST_DONE;
                        n_out.last   = 1'b1;
                    end
                end else begin
                    if (r_pend[r_idx] && (r_n != CNT_W'(MAX_OUT))) begin
                        n_out_valid       = 1'b1;
                        n_out.status      = ST_READY;
                        n_out.slot_number = 4'(r_idx);
                        n_out.ready_tag   = rec.tag;
                        n_out.last        = (pend_above == '0) ||
                                            (r_n == CNT_W'(MAX_OUT - 1));
                        n_n               = r_n + 1'b1;
                        o_mem_we          = 1'b1;
                        o_mem_wdata.runs  = runs_dec;
                        if (rec.period == '0) begin
                            n_used[r_idx] = 1'b0;
                            n_pend[r_idx] = 1'b0;
                        end else begin
                            n_pend[r_idx] = (runs_dec != '0);
                        end
                    end else if ((r_idx == IDX_LAST) && (r_n == '0)) begin
                        n_out_valid  = 1'b1;
                        n_out.status = ST_NONE;
                        n_out.last   = 1'b1;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_TICK;
            r_idx       <= '0;
            r_n         <= '0;
            r_used      <= '0;
            r_pend      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_used      <= n_used;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_valid;
    assign o_result = r_out;

endmodule

[design/periodic_task_slot_scheduler.sv]
// Periodic task slot scheduler. A beat is accepted when start is high and
// busy is low; every beat produces one or more result beats, each shown on
// o_result for exactly one cycle with o_strobe high, the final one with last
// set. The receiver cannot stall, so it must take every strobed beat. An add
// or a delete is answered in the next cycle and busy never rises, so another
// beat may follow at once. A tick or a dispatch walks the slot memory one slot
// per cycle through its single read port and holds busy high until the last
// slot has been visited; only then can the next beat be accepted. Dispatch
// results stream out during the walk, at most one per cycle. No memory
// clearing pass follows reset: per-slot used bits in flip-flops mark which
// memory entries hold live data.

module periodic_task_slot_scheduler
    import pts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_item    i_item,
    output logic     o_strobe,
    output t_result  o_result
);

    // Slot index width; a single-slot table still uses one address bit.
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Memory port wiring between the sequencer and the slot table.
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    t_slot_rec         mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    t_slot_rec         mem_rdata;

    // The sequencer owns the used and pending flags, decodes each beat and
    // performs the read-modify-write walk over the table. Reads run one slot
    // ahead of the write-back, so the same entry is never read and written
    // in the same cycle and no forwarding is needed.
    pts_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    // The slot table holds tag, delay countdown, period and pending-run count
    // for every slot.
    pts_slot_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

endmodule

[design/pts_checker.sv]
module pts_assertions
    import pts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     busy,
    input  t_item    i_item,
    input  logic     o_strobe,
    input  t_result  o_result
);

    logic accept;
    assign accept = start && !busy;

    // A tick or dispatch must occupy the block while the table is walked.
    a_walk_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.op == OP_TICK || i_item.op == OP_DISPATCH) |=> busy)
        else $error("tick or dispatch accepted without going busy");

    // An add or delete answers with a single final beat in the next cycle.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.op == OP_ADD || i_item.op == OP_DELETE)
        |=> o_strobe && o_result.last && !busy)
        else $error("add or delete did not answer with one final beat");

    // Every beat other than a ready report is a lone final beat shown while
    // the block is free; a dispatch may end its ready reports mid-walk.
    a_last_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.status != ST_READY |-> o_result.last && !busy)
        else $error("single-beat answer shown while still busy");

    // Further beats can only follow while the walk is still running.
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy && o_result.status == ST_READY)
        else $error("non-final beat outside a dispatch walk");

endmodule

bind periodic_task_slot_scheduler pts_assertions u_pts_assertions (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

[dv/pts_checker.sv]
`timescale 1ns / 1ps

module pts_checker
    import pts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    busy,
    input  t_item   i_item,
    input  logic    o_strobe,
    input  t_result o_result,
    output int      o_fail_count,
    output int      o_backlog,
    output int      o_checked
);

    // Shadow copy of the slot table, kept in step with every accepted beat.
    logic      slot_live [SLOTS];
    t_slot_rec slot_copy [SLOTS];
    t_result   due_results [$];
    int        fail_count = 0;
    int        checked = 0;

    function automatic t_result reply(t_status st, int slot, logic [TAG_W-1:0] tag, logic fin);
        t_result r;
        r.status      = st;
        r.slot_number = 4'(slot);
        r.ready_tag   = tag;
        r.last        = fin;
        return r;
    endfunction

    task automatic free_slot(input int s);
        slot_live[s] = 1'b0;
        slot_copy[s] = '0;
    endtask

    task automatic age_slots();
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_live[s]) begin
                if (slot_copy[s].delay == '0) begin
                    if (slot_copy[s].runs != RUN_MAX)
                        slot_copy[s].runs = slot_copy[s].runs + 1'b1;
                    if (slot_copy[s].period != '0)
                        slot_copy[s].delay = slot_copy[s].period;
                end else begin
                    slot_copy[s].delay = slot_copy[s].delay - 1'b1;
                end
            end
        end
        due_results.push_back(reply(ST_DONE, 0, '0, 1'b1));
    endtask

    task automatic place_task(input t_item it);
        int free_at;
        free_at = -1;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!slot_live[s])
                free_at = s;
        end
        if (free_at < 0) begin
            due_results.push_back(reply(ST_FULL, 0, '0, 1'b1));
        end else begin
            slot_live[free_at]        = 1'b1;
            slot_copy[free_at].tag    = it.task_tag;
            slot_copy[free_at].delay  = it.first_delay;
            slot_copy[free_at].period = it.repeat_period;
            slot_copy[free_at].runs   = '0;
            due_results.push_back(reply(ST_DONE, free_at, '0, 1'b1));
        end
    endtask

    task automatic remove_task(input t_item it);
        int idx;
        idx = int'(it.target_slot);
        if (idx >= SLOTS) begin
            due_results.push_back(reply(ST_INVALID, 0, '0, 1'b1));
        end else if (!slot_live[idx]) begin
            due_results.push_back(reply(ST_INVALID, 0, '0, 1'b1));
        end else begin
            free_slot(idx);
            due_results.push_back(reply(ST_DONE, 0, '0, 1'b1));
        end
    endtask

    // Ready slots go out in slot order, capped at MAX_OUT per dispatch.
    task automatic dispatch_ready();
        int total;
        int n;
        total = 0;
        for (int s = 0; s < SLOTS; s++) begin
            if (slot_copy[s].runs != '0 && total < MAX_OUT)
                total++;
        end
        n = 0;
        for (int s = 0; s < SLOTS && n < total; s++) begin
            if (slot_copy[s].runs != '0) begin
                n++;
                due_results.push_back(reply(ST_READY, s, slot_copy[s].tag, n == total));
                slot_copy[s].runs = slot_copy[s].runs - 1'b1;
                if (slot_copy[s].period == '0)
                    free_slot(s);
            end
        end
        if (total == 0)
            due_results.push_back(reply(ST_NONE, 0, '0, 1'b1));
    endtask

    task automatic compare_beat(input t_result want, input t_result got);
        if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fail_count++;
        end
        if (got.slot_number !== want.slot_number) begin
            $error("slot_number: expected %0d, actual %0d", want.slot_number, got.slot_number);
            fail_count++;
        end
        if (got.ready_tag !== want.ready_tag) begin
            $error("ready_tag: expected 0x%04h, actual 0x%04h", want.ready_tag, got.ready_tag);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++)
                free_slot(s);
            due_results.delete();
        end else begin
            // A result beat belongs to an earlier command, so check before predicting.
            if (o_strobe === 1'b1) begin
                checked++;
                if (due_results.size() == 0) begin
                    $error("result beat with status %0d arrived with nothing expected",
                           o_result.status);
                    fail_count++;
                end else begin
                    compare_beat(due_results.pop_front(), o_result);
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                case (i_item.op)
                    OP_TICK:     age_slots();
                    OP_ADD:      place_task(i_item);
                    OP_DELETE:   remove_task(i_item);
                    OP_DISPATCH: dispatch_ready();
                    default:     ;
                endcase
            end
        end
        o_fail_count <= fail_count;
        o_backlog    <= due_results.size();
        o_checked    <= checked;
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the periodic task slot scheduler. The checker
// beside the block watches both channels and keeps its own copy of the slot
// table; this module only produces command beats and reports the outcome.
module tb_top;
    import pts_pkg::*;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    t_item   i_item = '0;
    logic    o_strobe;
    t_result o_result;

    int fail_count;
    int backlog;
    int checked;
    int op_count [4] = '{0, 0, 0, 0};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    periodic_task_slot_scheduler #(.SLOTS(SLOTS_DEF)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    pts_checker #(.SLOTS(SLOTS_DEF)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .o_strobe     (o_strobe),
        .o_result     (o_result),
        .o_fail_count (fail_count),
        .o_backlog    (backlog),
        .o_checked    (checked)
    );

    function automatic t_item cmd(t_op op, logic [TAG_W-1:0] tag, logic [TIME_W-1:0] dly,
                                  logic [TIME_W-1:0] per, logic [7:0] slot);
        t_item it;
        it.op            = op;
        it.task_tag      = tag;
        it.first_delay   = dly;
        it.repeat_period = per;
        it.target_slot   = slot;
        return it;
    endfunction

    // Mostly short delays so that slots actually fire, with the occasional
    // full-range value to exercise every bit of the time fields.
    function automatic logic [TIME_W-1:0] pick_time();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return TIME_W'($urandom_range(3));
        else if (roll < 85)
            return TIME_W'($urandom_range(40, 4));
        else
            return TIME_W'($urandom());
    endfunction

    // Random commands are weighted toward ticks and adds so that the table
    // fills, ages and drains; deletes mostly name a real slot number, and
    // fields the command ignores still carry random noise.
    function automatic t_item random_cmd();
        t_item       it;
        int unsigned roll;
        it.task_tag      = TAG_W'($urandom());
        it.first_delay   = pick_time();
        it.repeat_period = ($urandom_range(99) < 40) ? '0 : pick_time();
        it.target_slot   = ($urandom_range(99) < 85) ? 8'($urandom_range(SLOTS_DEF - 1))
                                                     : 8'($urandom());
        roll = $urandom_range(99);
        if (roll < 35)
            it.op = OP_TICK;
        else if (roll < 60)
            it.op = OP_ADD;
        else if (roll < 80)
            it.op = OP_DELETE;
        else
            it.op = OP_DISPATCH;
        return it;
    endfunction

    // Present one command beat and hold it until the block takes it. With
    // some probability the sender first goes quiet for a random stretch that can
    // outlast a full scan, so that gaps land at every point of a tick or dispatch.
    // The busy value read right after the edge is the one the block saw.
    task automatic send_beat(input t_item it, input int idle_pct);
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(SLOTS_DEF + 2, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        op_count[it.op]++;
    endtask

    // Hard stop in case the block hangs; a correct run needs a small
    // fraction of this.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int idle_mix [3];
        idle_mix = '{0, 55, 36};

        // Synchronous reset, asserted from time zero and then released.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. An empty table gives nothing ready, a harmless tick
        // and invalid deletes for a free slot and for slot numbers just past
        // and far past the end of the table.
        send_beat(cmd(OP_DISPATCH, 16'hFFFF, '1, '1, 8'hFF), 0);
        send_beat(cmd(OP_TICK, '0, '0, '0, '0), 0);
        send_beat(cmd(OP_DELETE, '0, '0, '0, 8'd0), 0);
        send_beat(cmd(OP_DELETE, '0, '0, '0, 8'(SLOTS_DEF)), 0);
        send_beat(cmd(OP_DELETE, '0, '0, '0, 8'hFF), 0);

        // Tag zero as a one-shot due at once, an all-ones task that never
        // comes due, and a task with period one.
        send_beat(cmd(OP_ADD, 16'h0000, '0, '0, '0), 0);
        send_beat(cmd(OP_ADD, 16'hFFFF, '1, '1, '0), 0);
        send_beat(cmd(OP_ADD, 16'h1234, 32'd1, 32'd1, '0), 0);

        // Two ticks give the one-shot two runs; dispatch frees it and drops
        // the second run, while the periodic task keeps its slot.
        send_beat(cmd(OP_TICK, '0, '0, '0, '0), 0);
        send_beat(cmd(OP_TICK, '0, '0, '0, '0), 0);
        send_beat(cmd(OP_DISPATCH, '0, '0, '0, '0), 0);
        send_beat(cmd(OP_DELETE, '0, '0, '0, 8'd1), 0);

        // Fill every free slot with short delays, then overflow the table.
        for (int i = 0; i < SLOTS_DEF - 1; i++)
            send_beat(cmd(OP_ADD, TAG_W'($urandom()), TIME_W'(i % 3), TIME_W'(i % 4), '0), 0);
        send_beat(cmd(OP_ADD, 16'hBEEF, '0, '0, '0), 0);

        // Long aging run on a full table, cycling through the idling phases:
        // the one-shot slots keep gaining runs until the count saturates, and
        // the first dispatch afterwards reports all sixteen slots. The second
        // drains periodic slots only.
        for (int i = 0; i < 258; i++)
            send_beat(cmd(OP_TICK, TAG_W'($urandom()), '0, '0, '0), idle_mix[i % 3]);
        send_beat(cmd(OP_DISPATCH, '0, '0, '0, '0), 36);
        send_beat(cmd(OP_DISPATCH, '0, '0, '0, '0), 36);

        // Random part in three idling phases: back to back, a sender that is
        // quiet more often than not, and a moderate mix.
        foreach (idle_mix[p]) begin
            for (int i = 0; i < 8; i++)
                send_beat(random_cmd(), idle_mix[p]);
        end

        // Drain: wait until every predicted result beat has come back, then
        // keep the clock running so that any stray beat still has time to show.
        start <= 1'b0;
        @(posedge i_clk);
        while (backlog != 0)
            @(posedge i_clk);
        repeat (2 * SLOTS_DEF + 4) @(posedge i_clk);

        $display("Sent %0d tick, %0d add, %0d delete and %0d dispatch beats",
                 op_count[OP_TICK], op_count[OP_ADD], op_count[OP_DELETE],
                 op_count[OP_DISPATCH]);
        $display("Compared %0d result beats, with full-table, run saturation and idle phases",
                 checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[files.f]
design/pts_pkg.sv
design/pts_slot_mem.sv
design/pts_seq.sv
design/periodic_task_slot_scheduler.sv
design/pts_checker.sv
dv/pts_checker.sv
dv/tb_top.sv
